// ----- rtl/iie_pkg.sv -----
package iie_pkg;

    localparam logic [7:0] OP_LIMM = 8'h02;
    localparam logic [7:0] OP_CND  = 8'h04;
    localparam logic [7:0] OP_OR   = 8'h10;
    localparam logic [7:0] OP_XOR  = 8'h11;
    localparam logic [7:0] OP_AND  = 8'h12;
    localparam logic [7:0] OP_SEXT = 8'h13;
    localparam logic [7:0] OP_ADD  = 8'h14;
    localparam logic [7:0] OP_SUB  = 8'h15;
    localparam logic [7:0] OP_MUL  = 8'h16;
    localparam logic [7:0] OP_SHL  = 8'h18;
    localparam logic [7:0] OP_SAR  = 8'h19;
    localparam logic [7:0] OP_DIV  = 8'h1a;
    localparam logic [7:0] OP_REM  = 8'h1b;
    localparam logic [7:0] OP_EQ   = 8'h20;
    localparam logic [7:0] OP_NE   = 8'h21;
    localparam logic [7:0] OP_LT   = 8'h22;
    localparam logic [7:0] OP_GE   = 8'h23;
    localparam logic [7:0] OP_LE   = 8'h24;
    localparam logic [7:0] OP_GT   = 8'h25;
    localparam logic [7:0] OP_TZ   = 8'h26;
    localparam logic [7:0] OP_TNZ  = 8'h27;

    localparam logic [16:0] ADV_LIMM = 17'd4;
    localparam logic [16:0] ADV_CND  = 17'd3;
    localparam logic [16:0] ADV_ALU  = 17'd5;
    localparam logic [16:0] ADV_CMP  = 17'd6;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic        busy;
        logic        done;
    } t_div_ctl;

endpackage

// ----- rtl/integer_instruction_execute.sv -----
// Integer instruction execute unit.
// Input channel (i_valid/o_ready) takes one decoded instruction request:
// opcode, immediate, two source and one destination register index, skip.
// Output channel (o_valid/i_ready) returns one result per request: write
// enable, index and value, instruction-pointer advance, sticky error flag.
// State is a 64x32 register file, kept in two synchronous RAM copies
// (registered read), plus the error flag. One request is in flight at a time.
// Most instructions pass through READ (register read) and EXEC (execute
// into the output register) before OUT; divide and remainder with a nonzero
// divisor also pass through DIV, where the 32-step radix-2 divider runs.
// A divide by zero goes from EXEC straight to OUT. Multiply uses one 32x32 product.
// The next request is taken as soon as the result is handed off; o_ready
// stays low while a result is held and i_ready is low.
// After reset the register file is cleared by a pass over all 64 entries,
// one entry per cycle, during which o_ready is low. The error flag clears at
// reset and stays set after any divide by zero.
module integer_instruction_execute
    import iie_pkg::*;
#(
    parameter int REG_COUNT = 64
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_mode,
    input  logic signed [31:0] i_immediate,
    input  logic [5:0]  i_src_a,
    input  logic [5:0]  i_src_b,
    input  logic [5:0]  i_dest,
    input  logic [15:0] i_skip_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_write_enable,
    output logic [5:0]  o_write_index,
    output logic signed [31:0] o_write_value,
    output logic [16:0] o_advance,
    output logic        o_error
);

    localparam int AW = $clog2(REG_COUNT);

    t_state r_state, n_state;

    logic [31:0] r_mem_a [REG_COUNT];
    logic [31:0] r_mem_b [REG_COUNT];
    logic [31:0] r_rd_a, r_rd_b;
    logic [31:0] r_r63;
    logic [AW-1:0] w_ra, w_rb;

    logic [AW-1:0] r_clr;
    logic [7:0]  r_op;
    logic [31:0] r_imm;
    logic [AW-1:0] r_ia, r_ib, r_id;
    logic [15:0] r_skip;
    logic        r_err;
    logic [31:0] r_a, r_b;

    logic        mem_we;
    logic [AW-1:0] mem_wa;
    logic [31:0] mem_wd;

    logic        res_we;
    logic [31:0] res_val;
    logic [16:0] res_adv;
    logic        res_err;
    logic        res_set;

    logic        div_start;
    t_div_ctl    div_ctl;
    logic [31:0] div_q, div_r;

    logic [31:0] w_prod;
    logic [31:0] w_sext;
    logic [31:0] w_mask;
    logic [4:0]  w_pos;
    logic        w_lt, w_gt;

    // read addresses follow the request being accepted
    assign w_ra = (i_valid && o_ready) ? i_src_a[AW-1:0] : r_ia;
    assign w_rb = (i_valid && o_ready) ? i_src_b[AW-1:0] : r_ib;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_a[mem_wa] <= mem_wd;
            r_mem_b[mem_wa] <= mem_wd;
        end
        r_rd_a <= r_mem_a[w_ra];
        r_rd_b <= r_mem_b[w_rb];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == AW'(REG_COUNT - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (i_valid) n_state = ST_READ;
            ST_READ:  n_state = ST_EXEC;
            ST_EXEC:  n_state = ((r_op == OP_DIV || r_op == OP_REM) && r_b != 32'd0)
                                ? ST_DIV : ST_OUT;
            ST_DIV:   if (div_ctl.done) n_state = ST_OUT;
            ST_OUT:   if (i_ready) n_state = i_valid ? ST_READ : ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready   = (r_state == ST_IDLE) || (r_state == ST_OUT && i_ready);
        o_valid   = (r_state == ST_OUT);
        div_start = (r_state == ST_EXEC) && (r_op == OP_DIV || r_op == OP_REM)
                    && r_b != 32'd0;
    end

    assign w_prod = r_a * r_b;
    assign w_pos  = r_r63[4:0] - 5'd1;
    assign w_mask = 32'hffff_ffff << w_pos;
    assign w_lt   = $signed(r_a) < $signed(r_b);
    assign w_gt   = $signed(r_b) < $signed(r_a);

    always_comb begin
        if ($signed(r_r63) <= 0) begin
            w_sext = 32'd0;
        end else if ($signed(r_r63) > 32) begin
            w_sext = r_a;
        end else if (r_a[w_pos]) begin
            w_sext = r_a | w_mask;
        end else begin
            w_sext = r_a & ~w_mask;
        end
    end

    always_comb begin
        res_we  = 1'b0;
        res_val = 32'd0;
        res_adv = 17'd0;
        res_set = 1'b0;
        unique case (r_op)
            OP_LIMM: begin res_we = 1'b1; res_val = r_imm; res_adv = ADV_LIMM; end
            OP_CND:  res_adv = r_a[0] ? ADV_CND : ADV_CND + {1'b0, r_skip};
            OP_OR:   begin res_we = 1'b1; res_val = r_a | r_b; res_adv = ADV_ALU; end
            OP_XOR:  begin res_we = 1'b1; res_val = r_a ^ r_b; res_adv = ADV_ALU; end
            OP_AND:  begin res_we = 1'b1; res_val = r_a & r_b; res_adv = ADV_ALU; end
            OP_SEXT: begin res_we = 1'b1; res_val = w_sext; res_adv = ADV_ALU; end
            OP_ADD:  begin res_we = 1'b1; res_val = r_a + r_b; res_adv = ADV_ALU; end
            OP_SUB:  begin res_we = 1'b1; res_val = r_a - r_b; res_adv = ADV_ALU; end
            OP_MUL:  begin res_we = 1'b1; res_val = w_prod; res_adv = ADV_ALU; end
            OP_SHL:  begin res_we = 1'b1; res_val = r_a << r_b[4:0]; res_adv = ADV_ALU; end
            OP_SAR:  begin
                res_we = 1'b1; res_val = $unsigned($signed(r_a) >>> r_b[4:0]);
                res_adv = ADV_ALU;
            end
            OP_DIV, OP_REM: begin
                if (r_b == 32'd0) begin
                    res_set = 1'b1;
                end else begin
                    res_we  = 1'b1;
                    res_adv = ADV_ALU;
                    res_val = (r_op == OP_DIV) ? div_q : div_r;
                end
            end
            OP_EQ:  begin res_we = 1'b1; res_val = {32{r_a == r_b}}; res_adv = ADV_CMP; end
            OP_NE:  begin res_we = 1'b1; res_val = {32{r_a != r_b}}; res_adv = ADV_CMP; end
            OP_LT:  begin res_we = 1'b1; res_val = {32{w_lt}}; res_adv = ADV_CMP; end
            OP_GE:  begin res_we = 1'b1; res_val = {32{!w_lt}}; res_adv = ADV_CMP; end
            OP_LE:  begin res_we = 1'b1; res_val = {32{!w_gt}}; res_adv = ADV_CMP; end
            OP_GT:  begin res_we = 1'b1; res_val = {32{w_gt}}; res_adv = ADV_CMP; end
            OP_TZ:  begin res_we = 1'b1; res_val = {32{(r_a & r_b) == 32'd0}}; res_adv = ADV_CMP; end
            OP_TNZ: begin res_we = 1'b1; res_val = {32{(r_a & r_b) != 32'd0}}; res_adv = ADV_CMP; end
            default: ;
        endcase
        res_err = r_err | res_set;
        if (res_err) res_adv = 17'd0;
    end

    logic w_commit;
    assign w_commit = (r_state == ST_EXEC && !div_start) || (r_state == ST_DIV && div_ctl.done);

    always_comb begin
        if (r_state == ST_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
            mem_wd = 32'd0;
        end else begin
            mem_we = w_commit && res_we;
            mem_wa = r_id;
            mem_wd = res_val;
        end
    end

    iie_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_ctl   (div_ctl),
        .o_quo   (div_q),
        .o_rem   (div_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_err   <= 1'b0;
            r_r63   <= 32'd0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + AW'(1);
            if (w_commit) r_err <= res_err;
            if (mem_we && mem_wa == AW'(REG_COUNT - 1)) r_r63 <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op   <= i_mode;
            r_imm  <= i_immediate;
            r_ia   <= i_src_a[AW-1:0];
            r_ib   <= i_src_b[AW-1:0];
            r_id   <= i_dest[AW-1:0];
            r_skip <= i_skip_length;
        end
        if (r_state == ST_READ) begin
            r_a <= r_rd_a;
            r_b <= r_rd_b;
        end
        if (w_commit) begin
            o_write_enable <= res_we;
            o_write_index  <= res_we ? 6'(r_id) : 6'd0;
            o_write_value  <= res_we ? res_val : 32'd0;
            o_advance      <= res_adv;
            o_error        <= res_err;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC || r_state == ST_DIV || r_state == ST_READ) |-> !o_ready)
        else $error("request accepted while busy");
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_err) && $past(i_rst_n) |-> r_err)
        else $error("error flag cleared");
    a_err_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> o_advance == 17'd0)
        else $error("advance nonzero under error");
    a_div_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_ctl.start |-> r_state == ST_EXEC)
        else $error("divider started out of sequence");
`endif

endmodule

// ----- rtl/iie_div.sv -----
module iie_div
    import iie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output t_div_ctl    o_ctl,
    output logic [31:0] o_quo,
    output logic [31:0] o_rem
);

    logic [31:0] r_q, n_q;
    logic [32:0] r_r, n_r;
    logic [31:0] r_d;
    logic        r_nq, r_nr;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] w_try;
    logic [31:0] w_aa, w_ab;

    assign w_aa  = i_a[31] ? (32'd0 - i_a) : i_a;
    assign w_ab  = i_b[31] ? (32'd0 - i_b) : i_b;
    assign w_try = {r_r[31:0], r_q[31]} - {1'b0, r_d};

    always_comb begin
        if (!w_try[32]) begin
            n_r = w_try;
            n_q = {r_q[30:0], 1'b1};
        end else begin
            n_r = {r_r[31:0], r_q[31]};
            n_q = {r_q[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q  <= w_aa;
            r_r  <= 33'd0;
            r_d  <= w_ab;
            r_nq <= i_a[31] ^ i_b[31];
            r_nr <= i_a[31];
        end else if (r_busy) begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    assign o_quo = r_nq ? (32'd0 - r_q) : r_q;
    assign o_rem = r_nr ? (32'd0 - r_r[31:0]) : r_r[31:0];
    assign o_ctl = '{start: i_start, busy: r_busy, done: r_done};

endmodule
